[rtl/core/dsa_pkg.sv]
// Shared constants, codes and item types for the dense slot allocator.
package dsa_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int VAL_W    = 32;

    localparam logic [1:0] KIND_ALLOC    = 2'd0;
    localparam logic [1:0] KIND_FREE     = 2'd1;
    localparam logic [1:0] KIND_CONTAINS = 2'd2;
    localparam logic [1:0] KIND_READ     = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_ALLOC = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] handle;
        logic [VAL_W-1:0]  value;
    } req_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] new_handle;
        logic [VAL_W-1:0]  read_value;
        logic              present;
        logic [CNT_W-1:0]  live_count;
        logic [1:0]        status;
    } rsp_item_t;

endpackage

[rtl/core/dsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/dense_slot_allocator_unit.sv]
// Dense slot allocator: handle tables and value store in synchronous RAMs.
// Allocate, contains and any rejected item finish in the lookup state; a read
// passes through the fetch state, a free through the fetch and swap states
// (chained RAM reads and two write rounds on the owner and slot tables).
// The next item is accepted at the edge that ends the result strobe, so the
// unit holds one item at a time.
// Reset clears the live count, the issued count and the control state; the
// RAM contents stay undefined and are never read before they are written.
module dense_slot_allocator_unit
    import dsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  req_item_t req,
    output logic      done,
    output rsp_item_t rsp
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOOK  = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_SWAP  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  issued_reg, issued_next;
    logic [1:0]        kind_reg;
    logic [ADDR_W-1:0] handle_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [ADDR_W-1:0] slot_reg, slot_next;
    logic              done_reg, done_next;
    rsp_item_t         rsp_reg, rsp_next;

    logic              val_we, own_we, sl_we;
    logic [ADDR_W-1:0] val_waddr, own_waddr, sl_waddr;
    logic [VAL_W-1:0]  val_wdata;
    logic [ADDR_W-1:0] own_wdata, sl_wdata;
    logic [ADDR_W-1:0] val_raddr, own_raddr, sl_raddr;
    logic [VAL_W-1:0]  val_rdata;
    logic [ADDR_W-1:0] own_rdata, sl_rdata;

    logic              accept;
    logic [ADDR_W-1:0] last;
    logic [ADDR_W-1:0] count_lo;
    logic              live;
    logic              fresh;
    logic              full;
    logic [ADDR_W-1:0] alloc_handle;

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign count_lo = count_reg[ADDR_W-1:0];
    assign last     = ADDR_W'(count_reg - CNT_W'(1));
    assign live     = ({1'b0, handle_reg} < issued_reg) && ({1'b0, sl_rdata} < count_reg);
    assign fresh    = (issued_reg <= count_reg);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign alloc_handle = fresh ? count_lo : own_rdata;

    assign sl_raddr  = (state_reg == ST_IDLE) ? req.handle : handle_reg;
    assign own_raddr = (state_reg == ST_IDLE) ? count_lo : last;
    assign val_raddr = (kind_reg == KIND_READ) ? sl_rdata : last;

    dsa_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_values (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    dsa_ram #(.WIDTH(ADDR_W), .DEPTH(CAPACITY)) u_owner (
        .clk   (clk),
        .we    (own_we),
        .waddr (own_waddr),
        .wdata (own_wdata),
        .raddr (own_raddr),
        .rdata (own_rdata)
    );

    dsa_ram #(.WIDTH(ADDR_W), .DEPTH(CAPACITY)) u_slot (
        .clk   (clk),
        .we    (sl_we),
        .waddr (sl_waddr),
        .wdata (sl_wdata),
        .raddr (sl_raddr),
        .rdata (sl_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        issued_next = issued_reg;
        slot_next   = slot_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        val_we      = 1'b0;
        val_waddr   = count_lo;
        val_wdata   = value_reg;
        own_we      = 1'b0;
        own_waddr   = count_lo;
        own_wdata   = count_lo;
        sl_we       = 1'b0;
        sl_waddr    = count_lo;
        sl_wdata    = count_lo;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                rsp_next.new_handle = '0;
                rsp_next.read_value = '0;
                rsp_next.present    = 1'b0;
                rsp_next.live_count = count_reg;
                rsp_next.status     = STATUS_OK;
                case (kind_reg)
                    KIND_ALLOC:
                    begin
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                        if (full)
                        begin
                            rsp_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            val_we = 1'b1;
                            if (fresh)
                            begin
                                own_we      = 1'b1;
                                sl_we       = 1'b1;
                                issued_next = count_reg + CNT_W'(1);
                            end
                            count_next          = count_reg + CNT_W'(1);
                            rsp_next.new_handle = alloc_handle;
                            rsp_next.present    = 1'b1;
                            rsp_next.live_count = count_reg + CNT_W'(1);
                        end
                    end
                    KIND_CONTAINS:
                    begin
                        state_next       = ST_IDLE;
                        done_next        = 1'b1;
                        rsp_next.present = live;
                    end
                    default:
                    begin
                        if (!live)
                        begin
                            state_next      = ST_IDLE;
                            done_next       = 1'b1;
                            rsp_next.status = STATUS_NOT_ALLOC;
                        end
                        else
                        begin
                            state_next = ST_FETCH;
                            slot_next  = sl_rdata;
                        end
                    end
                endcase
            end
            ST_FETCH:
            begin
                if (kind_reg == KIND_READ)
                begin
                    state_next          = ST_IDLE;
                    done_next           = 1'b1;
                    rsp_next.read_value = val_rdata;
                    rsp_next.present    = 1'b1;
                end
                else
                begin
                    // move last entry into the freed slot
                    state_next = ST_SWAP;
                    val_we     = 1'b1;
                    val_waddr  = slot_reg;
                    val_wdata  = val_rdata;
                    own_we     = 1'b1;
                    own_waddr  = slot_reg;
                    own_wdata  = own_rdata;
                    sl_we      = 1'b1;
                    sl_waddr   = own_rdata;
                    sl_wdata   = slot_reg;
                end
            end
            ST_SWAP:
            begin
                state_next          = ST_IDLE;
                done_next           = 1'b1;
                own_we              = 1'b1;
                own_waddr           = last;
                own_wdata           = handle_reg;
                sl_we               = 1'b1;
                sl_waddr            = handle_reg;
                sl_wdata            = last;
                count_next          = count_reg - CNT_W'(1);
                rsp_next.live_count = count_reg - CNT_W'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            issued_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            issued_reg <= issued_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= req.kind;
            handle_reg <= req.handle;
            value_reg  <= req.value;
        end
        slot_reg <= slot_next;
        rsp_reg  <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_count_le_issued: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= issued_reg)
        else $error("live count exceeds issued handles");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("accepted item did not hold the unit busy");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status == STATUS_FULL) |-> rsp.live_count == CNT_W'(CAPACITY))
        else $error("full reported below capacity");

    a_free_decrement: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWAP) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("free did not decrement live count");

endmodule

[test/tb_top.sv]
// Testbench for dense_slot_allocator_unit: directed and random items against a scoreboard.
module tb_top
    import dsa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    class slot_ledger;
        bit [VAL_W-1:0]  slot_value  [CAPACITY];
        bit [ADDR_W-1:0] slot_owner  [CAPACITY];
        bit [ADDR_W-1:0] handle_slot [CAPACITY];
        int live;
        int issued;
        int mismatches;
        rsp_item_t awaited[$];

        function new();
            live = 0;
            issued = 0;
            mismatches = 0;
        endfunction

        function bit handle_live(bit [ADDR_W-1:0] h);
            return (h < issued) && (handle_slot[h] < live);
        endfunction

        function void note_op(req_item_t op);
            rsp_item_t       exp;
            bit [ADDR_W-1:0] s;
            bit [ADDR_W-1:0] last;
            bit [ADDR_W-1:0] moved;
            exp = '0;
            case (op.kind)
                KIND_ALLOC:
                begin
                    if (live >= CAPACITY)
                    begin
                        exp.status = STATUS_FULL;
                    end
                    else
                    begin
                        s = ADDR_W'(live);
                        if (issued <= live)
                        begin
                            slot_owner[s] = s;
                            handle_slot[s] = s;
                            issued = live + 1;
                        end
                        slot_value[s] = op.value;
                        exp.new_handle = slot_owner[s];
                        exp.present = 1'b1;
                        live++;
                    end
                end
                KIND_FREE:
                begin
                    if (!handle_live(op.handle))
                    begin
                        exp.status = STATUS_NOT_ALLOC;
                    end
                    else
                    begin
                        s = handle_slot[op.handle];
                        last = ADDR_W'(live - 1);
                        moved = slot_owner[last];
                        slot_value[s] = slot_value[last];
                        slot_owner[s] = moved;
                        slot_owner[last] = op.handle;
                        handle_slot[moved] = s;
                        handle_slot[op.handle] = last;
                        live = live - 1;
                    end
                end
                KIND_CONTAINS:
                begin
                    exp.present = handle_live(op.handle);
                end
                default:
                begin
                    if (!handle_live(op.handle))
                    begin
                        exp.status = STATUS_NOT_ALLOC;
                    end
                    else
                    begin
                        exp.read_value = slot_value[handle_slot[op.handle]];
                        exp.present = 1'b1;
                    end
                end
            endcase
            exp.live_count = CNT_W'(live);
            awaited = {awaited, exp};
        endfunction

        function void match_rsp(rsp_item_t got);
            rsp_item_t exp;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: live_count %0d status %0d",
                       got.live_count, got.status);
                mismatches++;
                return;
            end
            exp = awaited.pop_front();
            if (got.new_handle !== exp.new_handle)
            begin
                $error("new_handle: expected %0d, actual %0d", exp.new_handle, got.new_handle);
                mismatches++;
            end
            if (got.read_value !== exp.read_value)
            begin
                $error("read_value: expected %08h, actual %08h", exp.read_value, got.read_value);
                mismatches++;
            end
            if (got.present !== exp.present)
            begin
                $error("present: expected %0d, actual %0d", exp.present, got.present);
                mismatches++;
            end
            if (got.live_count !== exp.live_count)
            begin
                $error("live_count: expected %0d, actual %0d", exp.live_count, got.live_count);
                mismatches++;
            end
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                mismatches++;
            end
        endfunction

        function bit [ADDR_W-1:0] pick_handle();
            int roll;
            roll = $urandom_range(0, 99);
            if (live > 0 && roll < 75)
            begin
                return slot_owner[$urandom_range(0, live - 1)];
            end
            if (issued > 0 && roll < 88)
            begin
                return ADDR_W'($urandom_range(0, issued - 1));
            end
            return ADDR_W'($urandom_range(0, CAPACITY - 1));
        endfunction
    endclass

    localparam int RANDOM_OPS  = 1400;
    localparam int CYCLE_LIMIT = 200000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    req_item_t req;
    logic      done;
    rsp_item_t rsp;

    slot_ledger ledger = new();
    int         cycle_count = 0;
    int         idle_pct = 0;
    int         full_hits = 0;
    bit         draining = 1'b0;
    int         phase_idle [4] = '{0, 65, 0, 6};

    dense_slot_allocator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // check before noting, so a result never meets its own item in one step
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (done === 1'b1)
            begin
                ledger.match_rsp(rsp);
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                ledger.note_op(req);
            end
        end
    end

    task automatic issue_op(input logic [1:0] kind, input logic [ADDR_W-1:0] handle,
                            input logic [VAL_W-1:0] value);
        req_item_t item;
        item.kind = kind;
        item.handle = handle;
        item.value = value;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic random_op();
        int         roll;
        logic [1:0] kind;
        roll = $urandom_range(0, 99);
        if (!draining)
        begin
            kind = (roll < 72) ? KIND_ALLOC : (roll < 82) ? KIND_FREE :
                   (roll < 91) ? KIND_CONTAINS : KIND_READ;
        end
        else
        begin
            kind = (roll < 12) ? KIND_ALLOC : (roll < 70) ? KIND_FREE :
                   (roll < 85) ? KIND_CONTAINS : KIND_READ;
        end
        issue_op(kind, ledger.pick_handle(), $urandom());
        if (!draining && ledger.live >= CAPACITY)
        begin
            full_hits++;
            if (full_hits >= 4)
            begin
                draining = 1'b1;
                full_hits = 0;
            end
        end
        else if (draining && ledger.live == 0 && $urandom_range(0, 9) == 0)
        begin
            draining = 1'b0;
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        req <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_op(KIND_CONTAINS, 8'd0, 32'h0);
        issue_op(KIND_READ, 8'd255, 32'hFFFF_FFFF);
        issue_op(KIND_FREE, 8'd0, 32'h0);
        issue_op(KIND_ALLOC, 8'd255, 32'h0000_0000);
        issue_op(KIND_ALLOC, 8'd0, 32'hFFFF_FFFF);
        issue_op(KIND_ALLOC, 8'd0, 32'hA5A5_A5A5);
        issue_op(KIND_READ, 8'd1, 32'h0);
        issue_op(KIND_READ, 8'd0, 32'h0);
        issue_op(KIND_CONTAINS, 8'd2, 32'h0);
        issue_op(KIND_CONTAINS, 8'd3, 32'h0);
        issue_op(KIND_FREE, 8'd0, 32'h0);
        issue_op(KIND_FREE, 8'd0, 32'h0);
        issue_op(KIND_READ, 8'd0, 32'h0);
        issue_op(KIND_CONTAINS, 8'd0, 32'h0);
        issue_op(KIND_READ, 8'd2, 32'h0);
        issue_op(KIND_ALLOC, 8'd7, 32'h5A5A_5A5A);
        issue_op(KIND_READ, 8'd0, 32'h0);
        issue_op(KIND_FREE, 8'd2, 32'h0);
        issue_op(KIND_FREE, 8'd1, 32'h0);
        issue_op(KIND_FREE, 8'd0, 32'h0);
        issue_op(KIND_FREE, 8'd255, 32'h0);
        issue_op(KIND_ALLOC, 8'd0, 32'h1234_5678);
        issue_op(KIND_READ, 8'd2, 32'h0);
        issue_op(KIND_CONTAINS, 8'd255, 32'h0);

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            idle_pct = phase_idle[n * 4 / RANDOM_OPS];
            random_op();
        end
        start <= 1'b0;

        while (ledger.awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (ledger.mismatches == 0 && ledger.awaited.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
